>>> rtl/core/wcpc_pkg.sv
// ----------------------------------------------------------------------------
// wcpc_pkg
// Shared widths, register indexes, mode bits, class codes and helper
// functions of the waveform column pixel classifier.
// ----------------------------------------------------------------------------
package wcpc_pkg;

  // Bitmap height limit; the effective height h_eff saturates here
  localparam int MAX_ROWS   = 4096;
  localparam int HEIGHT_W   = 13;

  // Datapath widths
  localparam int VAL_W      = 24;          // scaled Q16 values, signed
  localparam int PROD_W     = 58;          // value times gain, signed
  localparam int ROW_W      = PROD_W - 32; // row numbers, signed

  // Registers from the accepting edge to the result strobe
  localparam int PIPE_DEPTH = 9;

  // Configuration register indexes
  localparam logic [2:0] REG_TOP_VALUE  = 3'd0;
  localparam logic [2:0] REG_ROW_GAIN   = 3'd1;
  localparam logic [2:0] REG_ROW_COUNT  = 3'd2;
  localparam logic [2:0] REG_MODE_FLAGS = 3'd3;
  localparam logic [2:0] REG_SEL_FIRST  = 3'd4;
  localparam logic [2:0] REG_SEL_LAST   = 3'd5;

  // mode_flags bit positions
  localparam int FLAG_CLIP  = 0;
  localparam int FLAG_RMS   = 1;
  localparam int FLAG_ENV   = 2;
  localparam int FLAG_DRAW  = 3;
  localparam int FLAG_SCALE = 4;

  // Color classes
  localparam logic [3:0] CLS_BLANK      = 4'd0;
  localparam logic [3:0] CLS_BG         = 4'd1;
  localparam logic [3:0] CLS_BG_SEL     = 4'd2;
  localparam logic [3:0] CLS_ENV        = 4'd3;
  localparam logic [3:0] CLS_ZERO       = 4'd4;
  localparam logic [3:0] CLS_SAMPLE     = 4'd5;
  localparam logic [3:0] CLS_SAMPLE_SEL = 4'd6;
  localparam logic [3:0] CLS_RMS        = 4'd7;
  localparam logic [3:0] CLS_RMS_SEL    = 4'd8;
  localparam logic [3:0] CLS_CLIP       = 4'd9;
  localparam logic [3:0] CLS_CLIP_SEL   = 4'd10;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ROW_W-1:0]  row_t;

  // Per-pixel side information that rides along the pipeline
  typedef struct packed {
    logic [11:0] row;
    logic        sel;
    logic        blank;
    logic        clip;
  } meta_t;

  // Band hits of one pixel
  typedef struct packed {
    logic rms;
    logic samp;
    logic zero;
    logic env;
  } hits_t;

  localparam val_t  ONE_Q16    = 24'sd65536;
  localparam prod_t ROUND_HALF = {{(PROD_W-32){1'b0}}, 1'b1, 31'b0};

  // Signed value times unsigned 32-bit gain
  function automatic prod_t mul_vg(val_t v, logic [31:0] g);
    logic signed [VAL_W+32:0] m;
    m = v * $signed({1'b0, g});
    return PROD_W'(m);
  endfunction

  // Divide by 2^32, truncating toward zero
  function automatic row_t trunc_row(prod_t p);
    row_t q;
    q = p[PROD_W-1:32];
    if (p[PROD_W-1] && (p[31:0] != 32'd0)) begin
      q = q + row_t'(1);
    end
    return q;
  endfunction

  // Clamp, the low bound wins when the bounds cross
  function automatic row_t clamp_row(row_t x, row_t lo, row_t hi);
    row_t y;
    y = x;
    if (y > hi) begin
      y = hi;
    end
    if (y < lo) begin
      y = lo;
    end
    return y;
  endfunction

endpackage

>>> rtl/core/waveform_column_pixel_classifier.sv
// ----------------------------------------------------------------------------
// waveform_column_pixel_classifier
// Classifies one waveform bitmap pixel per clock into a color class.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock (start while busy is low) and returns its
// color class on color_class with done high for one cycle; results come out
// in request order and cannot be held off. The pipeline has nine registers:
// input capture, envelope scaling multipliers, span selection, row gain
// multipliers, rounding sums, row truncation, clamps, band hits and the
// output register. busy is high only during reset. Configuration writes
// take effect at once and are meant for times when no request is in flight.
module waveform_column_pixel_classifier import wcpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [30:0]        column_pos,
  input  logic [11:0]        pixel_row,
  input  logic signed [19:0] col_min,
  input  logic signed [19:0] col_max,
  input  logic [18:0]        col_rms,
  input  logic [18:0]        envelope_level,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [3:0]         color_class
);

  // Configuration registers
  logic signed [19:0]  top_value;
  logic [31:0]         row_gain;
  logic [12:0]         row_count;
  logic [4:0]          mode_flags;
  logic signed [31:0]  sel_first;
  logic signed [31:0]  sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_value  <= 20'sd65536;
      row_gain   <= 32'd8355840;
      row_count  <= 13'd256;
      mode_flags <= 5'd3;
      sel_first  <= -32'sd1;
      sel_last   <= -32'sd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOP_VALUE:  top_value  <= cfg_data[19:0];
        REG_ROW_GAIN:   row_gain   <= cfg_data;
        REG_ROW_COUNT:  row_count  <= cfg_data[12:0];
        REG_MODE_FLAGS: mode_flags <= cfg_data[4:0];
        REG_SEL_FIRST:  sel_first  <= cfg_data;
        REG_SEL_LAST:   sel_last   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective height and derived constants
  logic [HEIGHT_W-1:0] h_eff;
  row_t                h_row;
  prod_t               half_g;
  logic                scale_en;

  assign h_eff    = (row_count > HEIGHT_W'(MAX_ROWS)) ? HEIGHT_W'(MAX_ROWS) : row_count;
  assign h_row    = ROW_W'(h_eff);
  assign half_g   = PROD_W'({row_gain, 15'b0});
  assign scale_en = mode_flags[FLAG_ENV] & mode_flags[FLAG_SCALE];

  // Handshake and valid chain
  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld;

  assign busy   = rst;
  assign accept = start & ~busy;
  assign done   = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  // Stage A: input capture
  logic [30:0]        a_pos;
  logic [11:0]        a_row;
  logic signed [19:0] a_min, a_max;
  logic [18:0]        a_rms, a_env;

  always_ff @(posedge clk) begin
    a_pos <= column_pos;
    a_row <= pixel_row;
    a_min <= col_min;
    a_max <= col_max;
    a_rms <= col_rms;
    a_env <= envelope_level;
  end

  // Stage B: envelope scaling products, selection and blank test
  logic signed [39:0] b_min_p, b_max_p;
  logic [37:0]        b_rms_p;
  logic signed [19:0] b_min, b_max;
  logic [18:0]        b_rms, b_env;
  meta_t              b_meta;

  always_ff @(posedge clk) begin
    b_min_p      <= a_min * $signed({1'b0, a_env});
    b_max_p      <= a_max * $signed({1'b0, a_env});
    b_rms_p      <= a_rms * a_env;
    b_min        <= a_min;
    b_max        <= a_max;
    b_rms        <= a_rms;
    b_env        <= a_env;
    b_meta.row   <= a_row;
    b_meta.sel   <= ($signed({1'b0, a_pos}) >= sel_first) &&
                    ($signed({1'b0, a_pos}) < sel_last);
    b_meta.blank <= (h_eff == '0) || ({1'b0, a_row} >= h_eff);
    b_meta.clip  <= 1'b0;
  end

  // Stage C: scaled values, clip test, rms span ends
  val_t  smin, smax, srms;
  val_t  c_min, c_max, c_pv, c_nv, c_env;
  meta_t c_meta;

  always_comb begin
    smin = scale_en ? b_min_p[39:16] : VAL_W'(b_min);
    smax = scale_en ? b_max_p[39:16] : VAL_W'(b_max);
    srms = scale_en ? {2'b00, b_rms_p[37:16]} : {5'b0, b_rms};
  end

  always_ff @(posedge clk) begin
    c_min        <= smin;
    c_max        <= smax;
    c_pv         <= (srms < smax) ? srms : smax;
    c_nv         <= (-srms > smin) ? -srms : smin;
    c_env        <= {5'b0, b_env};
    c_meta.row   <= b_meta.row;
    c_meta.sel   <= b_meta.sel;
    c_meta.blank <= b_meta.blank;
    c_meta.clip  <= mode_flags[FLAG_CLIP] && ((smin <= -ONE_Q16) || (smax >= ONE_Q16));
  end

  // Stage D: row gain products
  prod_t d_top_g, d_max_g, d_min_g, d_pv_g, d_nv_g, d_env_g;
  meta_t d_meta;

  always_ff @(posedge clk) begin
    d_top_g <= mul_vg(VAL_W'(top_value), row_gain);
    d_max_g <= mul_vg(c_max, row_gain);
    d_min_g <= mul_vg(c_min, row_gain);
    d_pv_g  <= mul_vg(c_pv, row_gain);
    d_nv_g  <= mul_vg(c_nv, row_gain);
    d_env_g <= mul_vg(c_env, row_gain);
    d_meta  <= c_meta;
  end

  // Stage E: (top - v) * gain or (top + v) * gain, with half-gain offsets for the envelope rows, plus rounding half
  prod_t e_max, e_min, e_pv, e_nv, e_zero, e_pe, e_ne, e_ph, e_nh;
  meta_t e_meta;

  always_ff @(posedge clk) begin
    e_max  <= d_top_g - d_max_g + ROUND_HALF;
    e_min  <= d_top_g - d_min_g + ROUND_HALF;
    e_pv   <= d_top_g - d_pv_g + ROUND_HALF;
    e_nv   <= d_top_g - d_nv_g + ROUND_HALF;
    e_zero <= d_top_g + ROUND_HALF;
    e_pe   <= d_top_g - d_env_g + ROUND_HALF;
    e_ne   <= d_top_g + d_env_g + ROUND_HALF;
    e_ph   <= d_top_g - d_env_g + half_g + ROUND_HALF;
    e_nh   <= d_top_g + d_env_g - half_g + ROUND_HALF;
    e_meta <= d_meta;
  end

  // Stage F: rows
  row_t  f_max, f_min, f_pr, f_nr, f_zero, f_pe, f_ne, f_ph, f_nh;
  meta_t f_meta;

  always_ff @(posedge clk) begin
    f_max  <= trunc_row(e_max);
    f_min  <= trunc_row(e_min);
    f_pr   <= trunc_row(e_pv);
    f_nr   <= trunc_row(e_nv);
    f_zero <= trunc_row(e_zero);
    f_pe   <= trunc_row(e_pe);
    f_ne   <= trunc_row(e_ne);
    f_ph   <= trunc_row(e_ph);
    f_nh   <= trunc_row(e_nh);
    f_meta <= e_meta;
  end

  // Stage G: clamped band limits and span ends
  row_t  g_posr, g_negr, g_ep, g_en, g_max, g_send, g_pr, g_nr, g_zero;
  logic  g_rms_ok;
  meta_t g_meta;

  always_ff @(posedge clk) begin
    g_posr   <= clamp_row(f_pe, '0, h_row);
    g_negr   <= clamp_row(f_ne + row_t'(1), '0, h_row);
    g_ep     <= clamp_row(f_ph, '0, f_zero);
    g_en     <= clamp_row(f_nh + row_t'(1), f_zero, h_row);
    g_max    <= f_max;
    g_send   <= (f_min == f_max) ? f_min + row_t'(1) : f_min;
    g_pr     <= f_pr;
    g_nr     <= f_nr;
    g_zero   <= f_zero;
    g_rms_ok <= f_nr >= f_pr;
    g_meta   <= f_meta;
  end

  // Stage H: band hits for this row
  row_t  g_r;
  hits_t h_hits;
  meta_t h_meta;

  assign g_r = ROW_W'(g_meta.row);

  always_ff @(posedge clk) begin
    h_hits.rms  <= mode_flags[FLAG_RMS] && g_rms_ok && (g_pr <= g_r) && (g_r < g_nr);
    h_hits.samp <= (g_max <= g_r) && (g_r < g_send);
    h_hits.zero <= g_r == g_zero;
    h_hits.env  <= mode_flags[FLAG_ENV] &&
                   (((g_negr <= g_r) && (g_r < h_row)) ||
                    (mode_flags[FLAG_DRAW] && (g_en != g_ep) &&
                     (g_ep <= g_r) && (g_r < g_en)) ||
                    (g_r < g_posr));
    h_meta      <= g_meta;
  end

  // Stage I: layer priority, topmost band wins
  logic [3:0] cls_next;

  always_comb begin
    priority if (h_meta.blank) begin
      cls_next = CLS_BLANK;
    end else if (h_meta.clip) begin
      cls_next = h_meta.sel ? CLS_CLIP_SEL : CLS_CLIP;
    end else if (h_hits.rms) begin
      cls_next = h_meta.sel ? CLS_RMS_SEL : CLS_RMS;
    end else if (h_hits.samp) begin
      cls_next = h_meta.sel ? CLS_SAMPLE_SEL : CLS_SAMPLE;
    end else if (h_hits.zero) begin
      cls_next = CLS_ZERO;
    end else if (h_hits.env) begin
      cls_next = CLS_ENV;
    end else begin
      cls_next = h_meta.sel ? CLS_BG_SEL : CLS_BG;
    end
  end

  always_ff @(posedge clk) begin
    color_class <= cls_next;
  end

endmodule

>>> rtl/core/wcpc_checker.sv
// ----------------------------------------------------------------------------
// wcpc_checker
// Port-level checks of the pixel classifier: fixed latency both ways and
// legal class codes.
// ----------------------------------------------------------------------------
module wcpc_checker import wcpc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [3:0]         color_class
);

  // Every accepted request yields its result once it has passed all pipeline registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("accepted pixel produced no result");

  // No result without a matching earlier transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without a matching request");

  // Class codes stay within the defined set
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (color_class <= CLS_CLIP_SEL))
    else $error("undefined color class");

endmodule

bind waveform_column_pixel_classifier wcpc_checker u_wcpc_checker (.*);
